@@ design/rbps_pkg.sv @@
// ----------------------------------------------------------------------------
// rbps_pkg
// Shared constants, codes and payload types of the ring buffer packet
// scheduler.
// ----------------------------------------------------------------------------
package rbps_pkg;

    // Buffer geometry (power of two, one position bit beyond the index)
    localparam int BUF_SIZE     = 2048;
    localparam int IDX_W        = $clog2(BUF_SIZE);
    localparam int POS_W        = IDX_W + 1;
    localparam int NUM_CHANNELS = 3;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int CH_W    = 2;
    localparam int LEN_W   = 7;
    localparam int FI_W    = 8;
    localparam int PS_W    = 7;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [PS_W-1:0] MAX_PACKET = PS_W'(64);

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_DONE  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE    = 1'd1;

    // Register reset values
    localparam logic [FI_W-1:0] FRAME_INTERVAL_RST = 8'd5;
    localparam logic [PS_W-1:0] PACKET_SIZE_RST    = 7'd64;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [CH_W-1:0]  channel;
        logic [IDX_W-1:0] write_index;
    } item_t;

    typedef struct packed {
        logic             start_res;
        logic [CH_W-1:0]  tx_channel;
        logic [IDX_W-1:0] tx_offset;
        logic [LEN_W-1:0] tx_length;
        logic             busy_res;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    ready;
    } hs_t;

endpackage

@@ design/rbps_if.sv @@
// ----------------------------------------------------------------------------
// rbps_if
// Request and result channels of the ring buffer packet scheduler.
// ----------------------------------------------------------------------------
interface rbps_in_if;
    logic                     valid;
    logic                     ready;
    logic [rbps_pkg::OP_W-1:0]  operation;
    logic [rbps_pkg::CH_W-1:0]  channel;
    logic [rbps_pkg::IDX_W-1:0] write_index;

    modport source (output valid, output operation, output channel,
                    output write_index, input ready);
    modport sink   (input valid, input operation, input channel,
                    input write_index, output ready);
endinterface

interface rbps_out_if;
    logic                       valid;
    logic                       ready;
    logic                       start_res;
    logic [rbps_pkg::CH_W-1:0]  tx_channel;
    logic [rbps_pkg::IDX_W-1:0] tx_offset;
    logic [rbps_pkg::LEN_W-1:0] tx_length;
    logic                       busy_res;

    modport source (output valid, output start_res, output tx_channel,
                    output tx_offset, output tx_length, output busy_res,
                    input ready);
    modport sink   (input valid, input start_res, input tx_channel,
                    input tx_offset, input tx_length, input busy_res,
                    output ready);
endinterface

@@ design/rbps_core.sv @@
// ----------------------------------------------------------------------------
// rbps_core
// Channel state, tick counter and single-pass scheduling of one request.
// ----------------------------------------------------------------------------
module rbps_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  rbps_pkg::item_t                  item,
    output rbps_pkg::result_t                res,
    input  logic                             cfg_write,
    input  logic [rbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbps_pkg::CFG_W-1:0]       cfg_data
);

    localparam logic [rbps_pkg::POS_W-1:0] BUF_END = rbps_pkg::POS_W'(rbps_pkg::BUF_SIZE);

    logic [rbps_pkg::POS_W-1:0] rp_reg   [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::POS_W-1:0] rp_next  [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::POS_W-1:0] rem_reg  [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::POS_W-1:0] rem_next [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::IDX_W-1:0] wp_reg   [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::IDX_W-1:0] wp_next  [rbps_pkg::NUM_CHANNELS];
    logic                       busy_reg;
    logic                       busy_next;
    logic [rbps_pkg::FI_W-1:0]  tick_reg;
    logic [rbps_pkg::FI_W-1:0]  tick_next;
    logic [rbps_pkg::FI_W-1:0]  fi_reg;
    logic [rbps_pkg::PS_W-1:0]  ps_reg;

    // Per-channel wrap and run length, all channels side by side
    logic [rbps_pkg::POS_W-1:0] wrap_pos [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::POS_W-1:0] run_len  [rbps_pkg::NUM_CHANNELS];
    logic                       has_data [rbps_pkg::NUM_CHANNELS];

    logic                       mapped;
    logic [rbps_pkg::PS_W-1:0]  ps_eff;
    logic                       issue;
    logic [rbps_pkg::CH_W-1:0]  issue_ch;
    logic [rbps_pkg::POS_W-1:0] issue_rp;
    logic [rbps_pkg::POS_W-1:0] issue_rem;
    logic [rbps_pkg::LEN_W-1:0] chunk_len;
    logic                       found;

    // Clamp packet size into 1..64
    always_comb
    begin
        if (ps_reg == '0)
            ps_eff = rbps_pkg::PS_W'(1);
        else if (ps_reg > rbps_pkg::MAX_PACKET)
            ps_eff = rbps_pkg::MAX_PACKET;
        else
            ps_eff = ps_reg;
    end

    assign mapped = (item.channel < rbps_pkg::CH_W'(rbps_pkg::NUM_CHANNELS));

    // Wrap read positions and size the contiguous run of each channel
    always_comb
    begin
        for (int i = 0; i < rbps_pkg::NUM_CHANNELS; i++)
        begin
            wrap_pos[i] = (rp_reg[i] >= BUF_END) ? '0 : rp_reg[i];
            has_data[i] = (wrap_pos[i] != {1'b0, wp_reg[i]});
            run_len[i]  = (wrap_pos[i] > {1'b0, wp_reg[i]}) ? (BUF_END - wrap_pos[i])
                                                             : ({1'b0, wp_reg[i]} - wrap_pos[i]);
        end
    end

    // Decode the request and pick the channel that transmits
    always_comb
    begin
        rp_next   = rp_reg;
        rem_next  = rem_reg;
        wp_next   = wp_reg;
        busy_next = busy_reg;
        tick_next = tick_reg;
        issue     = 1'b0;
        issue_ch  = '0;
        issue_rp  = '0;
        issue_rem = '0;
        found     = 1'b0;

        unique case (item.operation)
            rbps_pkg::OP_TICK:
            begin
                if (tick_reg == fi_reg)
                begin
                    tick_next = '0;
                    if (!busy_reg)
                    begin
                        for (int i = 0; i < rbps_pkg::NUM_CHANNELS; i++)
                        begin
                            if (!found)
                            begin
                                rp_next[i] = wrap_pos[i];
                                if (has_data[i])
                                begin
                                    found     = 1'b1;
                                    issue     = 1'b1;
                                    issue_ch  = rbps_pkg::CH_W'(i);
                                    issue_rp  = wrap_pos[i];
                                    issue_rem = run_len[i];
                                end
                            end
                        end
                        if (found)
                            busy_next = 1'b1;
                    end
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            rbps_pkg::OP_DONE:
            begin
                if (mapped && busy_reg)
                begin
                    if (rem_reg[item.channel] == '0)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        issue     = 1'b1;
                        issue_ch  = item.channel;
                        issue_rp  = rp_reg[item.channel];
                        issue_rem = rem_reg[item.channel];
                    end
                end
            end
            rbps_pkg::OP_WRITE:
            begin
                if (mapped)
                    wp_next[item.channel] = item.write_index;
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase

        // Cut the next chunk off the chosen run
        chunk_len = (issue_rem > {{(rbps_pkg::POS_W-rbps_pkg::PS_W){1'b0}}, ps_eff})
                  ? rbps_pkg::LEN_W'(ps_eff) : issue_rem[rbps_pkg::LEN_W-1:0];
        if (issue)
        begin
            rp_next[issue_ch]  = issue_rp
                               + {{(rbps_pkg::POS_W-rbps_pkg::LEN_W){1'b0}}, chunk_len};
            rem_next[issue_ch] = issue_rem
                               - {{(rbps_pkg::POS_W-rbps_pkg::LEN_W){1'b0}}, chunk_len};
        end

        res.start_res  = issue;
        res.tx_channel = issue ? issue_ch : '0;
        res.tx_offset  = issue ? issue_rp[rbps_pkg::IDX_W-1:0] : '0;
        res.tx_length  = issue ? chunk_len : '0;
        res.busy_res   = busy_next;
    end

    // Advance channel state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rbps_pkg::NUM_CHANNELS; i++)
            begin
                rp_reg[i]  <= '0;
                rem_reg[i] <= '0;
                wp_reg[i]  <= '0;
            end
            busy_reg <= 1'b0;
            tick_reg <= '0;
        end
        else if (fire)
        begin
            rp_reg   <= rp_next;
            rem_reg  <= rem_next;
            wp_reg   <= wp_next;
            busy_reg <= busy_next;
            tick_reg <= tick_next;
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg <= rbps_pkg::FRAME_INTERVAL_RST;
            ps_reg <= rbps_pkg::PACKET_SIZE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rbps_pkg::CFG_FRAME_INTERVAL: fi_reg <= cfg_data[rbps_pkg::FI_W-1:0];
                rbps_pkg::CFG_PACKET_SIZE:    ps_reg <= cfg_data[rbps_pkg::PS_W-1:0];
                default:                      fi_reg <= fi_reg;
            endcase
        end
    end

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.start_res) |-> (res.busy_res && res.tx_length != '0))
        else $error("packet issued without a busy path or with zero length");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !res.start_res) |-> (res.tx_length == '0 && res.tx_offset == '0))
        else $error("idle result carries a packet");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(fire && item.operation == rbps_pkg::OP_DONE))
        else $error("path went idle without a completion");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rp_reg[0]} + {1'b0, rem_reg[0]} <= {1'b0, BUF_END})
        && ({1'b0, rp_reg[rbps_pkg::NUM_CHANNELS-1]}
            + {1'b0, rem_reg[rbps_pkg::NUM_CHANNELS-1]} <= {1'b0, BUF_END}))
        else $error("pending run passes the buffer end");
`endif

endmodule

@@ design/rbps_skid.sv @@
// ----------------------------------------------------------------------------
// rbps_skid
// Output register with a skid stage, so a request is taken while a result
// still waits.
// ----------------------------------------------------------------------------
module rbps_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rbps_pkg::result_t in_data,
    output rbps_pkg::hs_t     out_hs,
    input  logic              out_ready,
    output rbps_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    rbps_pkg::result_t out_data_reg;
    rbps_pkg::result_t skid_data_reg;
    logic              in_fire;
    logic              out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign out_hs.valid = out_valid_reg;
    assign out_hs.ready = out_ready;
    assign out_data     = out_data_reg;

    // Track which stages hold a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move payload: drain the skid first, else load the new result
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire)
                out_data_reg <= in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

`ifndef SYNTH
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output stage is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled while the output stage could move");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");
`endif

endmodule

@@ design/ring_buffer_in_packet_scheduler.sv @@
// Each result is registered in the output register, or in the skid stage while that register is stalled.
// Throughput: one request per cycle; ready drops only while both the output
// register and the skid stage hold results not yet taken.
// All scheduling work is one combinational pass between request and result.
// Reset clears read, remaining and write positions, the tick counter and the
// busy flag, and loads frame_interval 5 and packet_size 64; no clearing pass.
// ----------------------------------------------------------------------------
// ring_buffer_in_packet_scheduler
// Schedules transmit packets (offset and length) from three ring buffers
// that share one transmit path.
// ----------------------------------------------------------------------------
module ring_buffer_in_packet_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbps_pkg::CFG_W-1:0]     cfg_data,
    rbps_in_if.sink                        item,
    rbps_out_if.source                     result
);

    rbps_pkg::item_t   item_data;
    rbps_pkg::result_t core_res;
    rbps_pkg::result_t out_data;
    rbps_pkg::hs_t     out_hs;
    logic              in_ready;
    logic              fire;

    // Gather the request fields
    assign item_data.operation   = item.operation;
    assign item_data.channel     = item.channel;
    assign item_data.write_index = item.write_index;

    assign item.ready = in_ready;
    assign fire       = item.valid && in_ready;

    rbps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item_data),
        .res       (core_res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rbps_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .in_data   (core_res),
        .out_hs    (out_hs),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    // Drive the result channel
    assign result.valid      = out_hs.valid;
    assign result.start_res  = out_data.start_res;
    assign result.tx_channel = out_data.tx_channel;
    assign result.tx_offset  = out_data.tx_offset;
    assign result.tx_length  = out_data.tx_length;
    assign result.busy_res   = out_data.busy_res;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring buffer packet scheduler. A short table of
// directed requests comes first, then random traffic under six register
// settings. Every accepted request goes through a cycle-free model of the
// scheduler, and each accepted result is compared field by field, in order,
// against what that model predicted, or against the table's value for a typed directed row.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 6;
    localparam logic [rbps_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic [rbps_pkg::CH_W-1:0] CH_UNMAPPED = 2'd3;

    typedef struct {
        rbps_pkg::item_t   req;
        bit                typed;
        rbps_pkg::result_t want;
    } dir_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [rbps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rbps_pkg::CFG_W-1:0]     cfg_data  = '0;

    rbps_in_if  item_if ();
    rbps_out_if result_if ();

    ring_buffer_in_packet_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    // Scheduler model state
    logic [rbps_pkg::POS_W-1:0] rd_pos [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::POS_W-1:0] remain [rbps_pkg::NUM_CHANNELS];
    logic [rbps_pkg::IDX_W-1:0] wr_pos [rbps_pkg::NUM_CHANNELS];
    logic                       path_busy_m;
    logic [7:0]                 tick_cnt;
    logic [rbps_pkg::FI_W-1:0]  cfg_interval;
    logic [rbps_pkg::PS_W-1:0]  cfg_pkt;
    logic [rbps_pkg::CH_W-1:0]  last_issue_ch;

    rbps_pkg::result_t pending_tx [$];
    dir_row_t          directed_rows [$];

    int        err_count     = 0;
    int        req_count     = 0;
    int        pkt_count     = 0;
    int        cycle_count   = 0;
    int        sender_idle_pct = 0;
    int        recv_idle_pct   = 0;
    int        hold_requests = 0;
    int        hold_served   = 0;
    int        hold_left     = 0;
    bit                cur_typed = 1'b0;
    rbps_pkg::result_t cur_want  = '0;

    initial
    begin
        item_if.valid       = 1'b0;
        item_if.operation   = '0;
        item_if.channel     = '0;
        item_if.write_index = '0;
        result_if.ready     = 1'b0;
        for (int c = 0; c < rbps_pkg::NUM_CHANNELS; c++)
        begin
            rd_pos[c] = '0;
            remain[c] = '0;
            wr_pos[c] = '0;
        end
        path_busy_m   = 1'b0;
        tick_cnt      = '0;
        cfg_interval  = rbps_pkg::FRAME_INTERVAL_RST;
        cfg_pkt       = rbps_pkg::PACKET_SIZE_RST;
        last_issue_ch = '0;
    end

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Send the next chunk of a channel's pending run
    function automatic rbps_pkg::result_t issue_packet(input int ch);
        rbps_pkg::result_t          r;
        logic [rbps_pkg::PS_W-1:0]  ps;
        logic [rbps_pkg::POS_W-1:0] len;
        r = '0;
        if (cfg_pkt == '0)
            ps = rbps_pkg::PS_W'(1);
        else if (cfg_pkt > rbps_pkg::MAX_PACKET)
            ps = rbps_pkg::MAX_PACKET;
        else
            ps = cfg_pkt;
        len = (remain[ch] > rbps_pkg::POS_W'(ps)) ? rbps_pkg::POS_W'(ps) : remain[ch];
        r.start_res  = 1'b1;
        r.tx_channel = rbps_pkg::CH_W'(ch);
        r.tx_offset  = rd_pos[ch][rbps_pkg::IDX_W-1:0];
        r.tx_length  = len[rbps_pkg::LEN_W-1:0];
        rd_pos[ch]   = rd_pos[ch] + len;
        remain[ch]   = remain[ch] - len;
        return r;
    endfunction

    // Advance the model by one request and return the result it produces
    function automatic rbps_pkg::result_t sched_predict(input rbps_pkg::item_t req);
        rbps_pkg::result_t          r;
        bit                         found;
        logic [rbps_pkg::POS_W-1:0] wp;
        int                         ch;
        r     = '0;
        found = 1'b0;
        ch    = int'(req.channel);
        case (req.operation)
            rbps_pkg::OP_TICK:
            begin
                if (tick_cnt == cfg_interval)
                begin
                    tick_cnt = '0;
                    if (!path_busy_m)
                    begin
                        for (int c = 0; c < rbps_pkg::NUM_CHANNELS && !found; c++)
                        begin
                            // wrap the read position at the buffer end
                            if (rd_pos[c] >= rbps_pkg::POS_W'(rbps_pkg::BUF_SIZE))
                                rd_pos[c] = '0;
                            wp = {1'b0, wr_pos[c]};
                            if (rd_pos[c] != wp)
                            begin
                                remain[c] = (rd_pos[c] > wp)
                                          ? rbps_pkg::POS_W'(rbps_pkg::BUF_SIZE) - rd_pos[c]
                                          : wp - rd_pos[c];
                                r = issue_packet(c);
                                path_busy_m = 1'b1;
                                found = 1'b1;
                            end
                        end
                    end
                end
                else
                    tick_cnt = tick_cnt + 8'd1;
            end
            rbps_pkg::OP_DONE:
            begin
                if (ch < rbps_pkg::NUM_CHANNELS && path_busy_m)
                begin
                    if (remain[ch] == '0)
                        path_busy_m = 1'b0;
                    else
                        r = issue_packet(ch);
                end
            end
            rbps_pkg::OP_WRITE:
            begin
                if (ch < rbps_pkg::NUM_CHANNELS)
                    wr_pos[ch] = req.write_index;
            end
            default:
            begin
            end
        endcase
        r.busy_res = path_busy_m;
        return r;
    endfunction

    // Check results, track register writes, predict each accepted request
    always @(posedge clk)
    begin : monitor
        rbps_pkg::result_t seen;
        rbps_pkg::result_t want;
        rbps_pkg::result_t got;
        rbps_pkg::item_t   req;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                seen.start_res  = result_if.start_res;
                seen.tx_channel = result_if.tx_channel;
                seen.tx_offset  = result_if.tx_offset;
                seen.tx_length  = result_if.tx_length;
                seen.busy_res   = result_if.busy_res;
                if (pending_tx.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("ERROR @%0d: result with nothing expected: %p",
                                 cycle_count, seen);
                end
                else
                begin
                    want = pending_tx.pop_front();
                    if (seen.start_res !== want.start_res || seen.tx_channel !== want.tx_channel
                        || seen.tx_offset !== want.tx_offset
                        || seen.tx_length !== want.tx_length
                        || seen.busy_res !== want.busy_res)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("ERROR @%0d: expected %p, got %p", cycle_count, want, seen);
                    end
                    if (want.start_res)
                        pkt_count++;
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == rbps_pkg::CFG_FRAME_INTERVAL)
                    cfg_interval = cfg_data;
                else
                    cfg_pkt = cfg_data[rbps_pkg::PS_W-1:0];
            end
            if (item_if.valid && item_if.ready)
            begin
                req.operation   = item_if.operation;
                req.channel     = item_if.channel;
                req.write_index = item_if.write_index;
                got = sched_predict(req);
                if (got.start_res)
                    last_issue_ch = got.tx_channel;
                pending_tx.push_back(cur_typed ? cur_want : got);
                req_count++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_if.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Offer one request, with random idle cycles first, and hold until taken
    task automatic send_req(input rbps_pkg::item_t req, input bit typed,
                            input rbps_pkg::result_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.operation   <= req.operation;
        item_if.channel     <= req.channel;
        item_if.write_index <= req.write_index;
        cur_typed = typed;
        cur_want  = want;
        do
            @(posedge clk);
        while (!item_if.ready);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (pending_tx.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [rbps_pkg::CFG_W-1:0] fi,
                                input logic [rbps_pkg::CFG_W-1:0] ps);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= rbps_pkg::CFG_FRAME_INTERVAL;
        cfg_data  <= fi;
        @(negedge clk);
        cfg_index <= rbps_pkg::CFG_PACKET_SIZE;
        cfg_data  <= ps;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_row(input logic [rbps_pkg::OP_W-1:0] op,
                           input logic [rbps_pkg::CH_W-1:0] ch,
                           input logic [rbps_pkg::IDX_W-1:0] wi, input bit typed,
                           input logic st, input logic [rbps_pkg::CH_W-1:0] tch,
                           input logic [rbps_pkg::IDX_W-1:0] off,
                           input logic [rbps_pkg::LEN_W-1:0] len,
                           input logic busy);
        dir_row_t row;
        row.req.operation   = op;
        row.req.channel     = ch;
        row.req.write_index = wi;
        row.typed           = typed;
        row.want.start_res  = st;
        row.want.tx_channel = tch;
        row.want.tx_offset  = off;
        row.want.tx_length  = len;
        row.want.busy_res   = busy;
        directed_rows.push_back(row);
    endtask

    initial
    begin : stimulus
        rbps_pkg::item_t            req;
        logic [rbps_pkg::CFG_W-1:0] fi;
        logic [rbps_pkg::CFG_W-1:0] ps;
        int              n_items;
        int              tick_w;
        int              counted;
        int              roll;
        int              pick;

        // Directed table, under reset register values (interval 5, size 64)
        add_row(rbps_pkg::OP_TICK,  2'd0, 11'd0,    1, 0, 0, 0, 0, 0);   // first tick, count 1
        add_row(OP_UNUSED, CH_UNMAPPED, 11'd2047, 1, 0, 0, 0, 0, 0);
        add_row(rbps_pkg::OP_DONE,  2'd0, 11'd0,    1, 0, 0, 0, 0, 0);   // completion while idle
        add_row(rbps_pkg::OP_WRITE, CH_UNMAPPED, 11'd1234, 1, 0, 0, 0, 0, 0);
        add_row(rbps_pkg::OP_DONE,  CH_UNMAPPED, 11'd0, 1, 0, 0, 0, 0, 0);
        add_row(rbps_pkg::OP_WRITE, 2'd0, 11'd2047, 1, 0, 0, 0, 0, 0);
        add_row(rbps_pkg::OP_WRITE, 2'd2, 11'd10,   1, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            add_row(rbps_pkg::OP_TICK, 2'd1, 11'd0, 1, 0, 0, 0, 0, 0);   // count 2..5
        add_row(rbps_pkg::OP_TICK,  2'd0, 11'd0,    1, 1, 2'd0, 11'd0, 7'd64, 1);
        for (int i = 0; i < 5; i++)
            add_row(rbps_pkg::OP_TICK, 2'd2, 11'd2047, 0, 0, 0, 0, 0, 0);
        add_row(rbps_pkg::OP_TICK,  2'd0, 11'd0,    1, 0, 0, 0, 0, 1);   // attempt while busy
        add_row(rbps_pkg::OP_DONE,  2'd0, 11'd0,    0, 0, 0, 0, 0, 0);   // next chunk
        add_row(rbps_pkg::OP_DONE,  2'd2, 11'd0,    1, 0, 0, 0, 0, 0);   // other channel, none left
        add_row(OP_UNUSED, 2'd1, 11'h555,  1, 0, 0, 0, 0, 0);
        add_row(rbps_pkg::OP_WRITE, 2'd1, 11'h2AA,  0, 0, 0, 0, 0, 0);

        // Hold reset, then release it
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 8;
        recv_idle_pct   = 82;
        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       begin fi = 8'd0;   ps = 8'd0;   n_items = 200; tick_w = 35; end
                1:       begin fi = 8'd0;   ps = 8'hFF;  n_items = 200; tick_w = 35; end
                2:       begin fi = 8'd255; ps = 8'd17;  n_items = 300; tick_w = 85; end
                3:       begin fi = 8'd3;   ps = 8'd64;  n_items = 250; tick_w = 60; end
                4:       begin fi = 8'd1;   ps = rbps_pkg::CFG_W'($urandom_range(1, 64));
                               n_items = 150; tick_w = 35; end
                default: begin fi = rbps_pkg::CFG_W'($urandom_range(0, 7)); ps = 8'd1;
                               n_items = 150; tick_w = 35; end
            endcase
            // idle mix: sender light / receiver heavy, then swapped, then none
            if (phase < 2)
            begin
                sender_idle_pct = 8;
                recv_idle_pct   = 82;
            end
            else if (phase < 4)
            begin
                sender_idle_pct = 82;
                recv_idle_pct   = 8;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            program_regs(fi, ps);
            if (phase == 4)
                hold_requests++;

            counted = 0;
            while (counted < n_items)
            begin
                roll = $urandom_range(0, 99);
                req.channel     = rbps_pkg::CH_W'($urandom_range(0, 3));
                req.write_index = rbps_pkg::IDX_W'($urandom_range(0, rbps_pkg::BUF_SIZE - 1));
                if (roll < 4)
                    req.operation = OP_UNUSED;
                else if (roll < 4 + tick_w)
                    req.operation = rbps_pkg::OP_TICK;
                else if (roll < 4 + tick_w + (96 - tick_w) / 2)
                begin
                    // completions mostly target the channel in flight
                    req.operation = rbps_pkg::OP_DONE;
                    if ($urandom_range(0, 9) < 8)
                        req.channel = last_issue_ch;
                end
                else
                begin
                    req.operation = rbps_pkg::OP_WRITE;
                    if ($urandom_range(0, 9) != 0)
                        req.channel = rbps_pkg::CH_W'($urandom_range(0,
                                                      rbps_pkg::NUM_CHANNELS - 1));
                    pick = $urandom_range(0, 9);
                    if (pick < 4 && req.channel < rbps_pkg::NUM_CHANNELS)
                        req.write_index = rd_pos[req.channel][rbps_pkg::IDX_W-1:0]
                                          + rbps_pkg::IDX_W'($urandom_range(1, 300));
                    else if (pick == 4)
                        req.write_index = rbps_pkg::IDX_W'(rbps_pkg::BUF_SIZE - 1);
                    else if (pick == 5)
                        req.write_index = '0;
                end
                send_req(req, 1'b0, '0);
                if (req.operation != OP_UNUSED
                    && !(req.operation != rbps_pkg::OP_TICK && req.channel == CH_UNMAPPED))
                    counted++;
                // pause the sender mid-phase until everything is back
                if (phase == 4 && counted == n_items / 2)
                    drain_results();
            end
            drain_results();
        end

        $display("Summary: %0d requests over %0d register settings, %0d packets issued.",
                 req_count, NUM_PHASES + 1, pkt_count);
        $display("Summary: idle mixes on both sides, one long result hold, %0d cycles.",
                 cycle_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
design/rbps_pkg.sv
design/rbps_if.sv
design/rbps_core.sv
design/rbps_skid.sv
design/ring_buffer_in_packet_scheduler.sv
tb/sv/tb_top.sv
